// ----- hw/rtl/k44bc_pkg.sv -----
// Shared types, constants and a helper function of the K44 biclique edge check block.
package k44bc_pkg;

  localparam int MaxNodes = 32;
  localparam int RowW     = MaxNodes;
  localparam int IdxW     = $clog2(MaxNodes);
  localparam int CntW     = IdxW + 1;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 6;

  localparam logic [CfgIdxW-1:0] CfgLeftCount  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgRightCount = 1'b1;

  localparam logic CmdWriteRow = 1'b0;
  localparam logic CmdQuery    = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_WRITE,
    OP_START,
    OP_SCAN,
    OP_INIT_I,
    OP_LOAD_A,
    OP_NEXT_I,
    OP_LOAD_B,
    OP_NEXT_J,
    OP_NEXT_K
  } op_e;

  typedef struct packed {
    op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_end;
    logic few_cands;
    logic i_end;
    logic a_ok;
    logic j_end;
    logic b_ok;
    logic k_end;
    logic k_hit;
  } dp_stat_t;

  // True when the word has at least three bits set.
  function automatic logic at_least_three(input logic [RowW-1:0] x);
    logic [RowW-1:0] x1;
    logic [RowW-1:0] x2;
    x1 = x & (x - RowW'(1));
    x2 = x1 & (x1 - RowW'(1));
    return x2 != '0;
  endfunction

endpackage

// ----- hw/rtl/k44_biclique_edge_check_top.sv -----
// Top level of the K44 biclique edge check block: stream ports, configuration port and wiring.
// A write request passes the done state before its acknowledge is registered; one request is worked at a time.
// A query first scans rows 0 to left_count - 1 (clamped to 32) for candidate rows, then tries third rows in
// the triple search for each row pair whose intersection keeps at least three columns.
// The triple loop of the controller tries one candidate row per cycle.
// Reset clears all adjacency rows at once and sets both counts to 32.
module k44_biclique_edge_check_top
  import k44bc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [47:0]         s_axis_tdata,  // row_index, row_bits, vertex_u, vertex_v, pad
  input  logic                s_axis_tuser,  // command
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,  // creates_biclique, pad
  output logic                m_axis_tuser,  // was_query
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     out_hit;

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = {7'b0, out_hit};

  k44bc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_command_i (s_axis_tuser),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_hit_o    (out_hit),
    .out_query_o  (m_axis_tuser),
    .cmd_o        (cmd),
    .stat_i       (stat)
  );

  k44bc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .row_index_i (s_axis_tdata[4:0]),
    .row_bits_i  (s_axis_tdata[36:5]),
    .vertex_u_i  (s_axis_tdata[41:37]),
    .vertex_v_i  (s_axis_tdata[46:42]),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .stat_o      (stat)
  );

endmodule

// ----- hw/rtl/k44bc_dp.sv -----
// Datapath: adjacency rows, candidate list, loop counters and intersection registers.
module k44bc_dp
  import k44bc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  input  logic [IdxW-1:0]     row_index_i,
  input  logic [RowW-1:0]     row_bits_i,
  input  logic [IdxW-1:0]     vertex_u_i,
  input  logic [IdxW-1:0]     vertex_v_i,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output dp_stat_t            stat_o
);

  logic [RowW-1:0]     rows_q [MaxNodes];
  logic [RowW-1:0]     cand_q [MaxNodes];
  logic [CfgDataW-1:0] left_count_q, right_count_q;
  logic [CntW-1:0]     nc_q, scan_q, i_q, j_q, k_q;
  logic [CntW-1:0]     lim_q;
  logic [IdxW-1:0]     u_q, v_q;
  logic [RowW-1:0]     base_q, a_q, b_q;

  logic [IdxW-1:0]     row_addr;
  logic [RowW-1:0]     row_rd;
  logic [IdxW-1:0]     cand_addr;
  logic [RowW-1:0]     cand_rd;
  logic [CntW-1:0]     left_clamp, right_clamp;
  logic [RowW:0]       mask_wide;
  logic [RowW-1:0]     col_mask;
  logic [RowW-1:0]     vbit_start;
  logic                is_cand;

  always_comb begin
    row_addr = (cmd_i.op == OP_START) ? vertex_u_i : scan_q[IdxW-1:0];
    row_rd   = rows_q[row_addr];
    case (cmd_i.op)
      OP_LOAD_A: cand_addr = i_q[IdxW-1:0];
      OP_LOAD_B: cand_addr = j_q[IdxW-1:0];
      default:   cand_addr = k_q[IdxW-1:0];
    endcase
    cand_rd = cand_q[cand_addr];

    left_clamp  = (CntW'(left_count_q) > CntW'(MaxNodes)) ? CntW'(MaxNodes)
                                                          : CntW'(left_count_q);
    right_clamp = (CntW'(right_count_q) > CntW'(MaxNodes)) ? CntW'(MaxNodes)
                                                           : CntW'(right_count_q);
    mask_wide   = ((RowW+1)'(1) << right_clamp) - (RowW+1)'(1);
    col_mask    = mask_wide[RowW-1:0];
    vbit_start  = RowW'(1) << vertex_v_i;
    is_cand     = row_rd[v_q] && (scan_q[IdxW-1:0] != u_q);
  end

  always_comb begin
    stat_o.scan_end  = scan_q >= lim_q;
    stat_o.few_cands = nc_q < CntW'(3);
    stat_o.i_end     = i_q >= nc_q;
    stat_o.a_ok      = at_least_three(a_q);
    stat_o.j_end     = j_q >= nc_q;
    stat_o.b_ok      = at_least_three(b_q);
    stat_o.k_end     = k_q >= nc_q;
    stat_o.k_hit     = at_least_three(b_q & cand_rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < MaxNodes; r++) begin
        rows_q[r] <= '0;
      end
      left_count_q  <= CfgDataW'(MaxNodes);
      right_count_q <= CfgDataW'(MaxNodes);
      nc_q          <= '0;
      scan_q        <= '0;
      i_q           <= '0;
      j_q           <= '0;
      k_q           <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgLeftCount:  left_count_q  <= cfg_data_i;
          CfgRightCount: right_count_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (cmd_i.op)
        OP_WRITE: rows_q[row_index_i] <= row_bits_i;
        OP_START: begin
          nc_q   <= '0;
          scan_q <= '0;
        end
        OP_SCAN: begin
          scan_q <= scan_q + CntW'(1);
          if (is_cand) begin
            nc_q <= nc_q + CntW'(1);
          end
        end
        OP_INIT_I: i_q <= '0;
        OP_LOAD_A: j_q <= i_q + CntW'(1);
        OP_NEXT_I: i_q <= i_q + CntW'(1);
        OP_LOAD_B: k_q <= j_q + CntW'(1);
        OP_NEXT_J: j_q <= j_q + CntW'(1);
        OP_NEXT_K: k_q <= k_q + CntW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_START: begin
        u_q    <= vertex_u_i;
        v_q    <= vertex_v_i;
        lim_q  <= left_clamp;
        base_q <= row_rd & col_mask & ~vbit_start;
      end
      OP_SCAN: begin
        if (is_cand) begin
          cand_q[nc_q[IdxW-1:0]] <= row_rd;
        end
      end
      OP_LOAD_A: a_q <= base_q & cand_rd;
      OP_LOAD_B: b_q <= a_q & cand_rd;
      default: ;
    endcase
  end

endmodule

// ----- hw/rtl/k44bc_ctrl.sv -----
// Controller: sequences the row scan and the triple search and owns both stream handshakes.
module k44bc_ctrl
  import k44bc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     in_command_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output logic     out_hit_o,
  output logic     out_query_o,
  output dp_cmd_t  cmd_o,
  input  dp_stat_t stat_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_I,
    S_A,
    S_J,
    S_B,
    S_K,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   hit_q, hit_d;
  logic   query_q, query_d;
  logic   out_valid_q, out_hit_q, out_query_q;
  logic   out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_hit_o   = out_hit_q;
  assign out_query_o = out_query_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d   = state_q;
    hit_d     = hit_q;
    query_d   = query_q;
    cmd_o.op  = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_command_i == CmdWriteRow) begin
            cmd_o.op = OP_WRITE;
            hit_d    = 1'b0;
            query_d  = 1'b0;
            state_d  = S_DONE;
          end else begin
            cmd_o.op = OP_START;
            hit_d    = 1'b0;
            query_d  = 1'b1;
            state_d  = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (!stat_i.scan_end) begin
          cmd_o.op = OP_SCAN;
        end else if (stat_i.few_cands) begin
          state_d = S_DONE;
        end else begin
          cmd_o.op = OP_INIT_I;
          state_d  = S_I;
        end
      end
      S_I: begin
        if (stat_i.i_end) begin
          state_d = S_DONE;
        end else begin
          cmd_o.op = OP_LOAD_A;
          state_d  = S_A;
        end
      end
      S_A: begin
        if (stat_i.a_ok) begin
          state_d = S_J;
        end else begin
          cmd_o.op = OP_NEXT_I;
          state_d  = S_I;
        end
      end
      S_J: begin
        if (stat_i.j_end) begin
          cmd_o.op = OP_NEXT_I;
          state_d  = S_I;
        end else begin
          cmd_o.op = OP_LOAD_B;
          state_d  = S_B;
        end
      end
      S_B: begin
        if (stat_i.b_ok) begin
          state_d = S_K;
        end else begin
          cmd_o.op = OP_NEXT_J;
          state_d  = S_J;
        end
      end
      S_K: begin
        if (stat_i.k_end) begin
          cmd_o.op = OP_NEXT_J;
          state_d  = S_J;
        end else if (stat_i.k_hit) begin
          hit_d   = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.op = OP_NEXT_K;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hit_q       <= 1'b0;
      query_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_hit_q   <= 1'b0;
      out_query_q <= 1'b0;
    end else begin
      state_q <= state_d;
      hit_q   <= hit_d;
      query_q <= query_d;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
        out_hit_q   <= hit_q;
        out_query_q <= query_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ----- bench/tb_k44_biclique_edge_check_top.sv -----
`timescale 1ns / 1ps
// Testbench of the K44 biclique edge check block: directed and random requests checked by a scoreboard.
module tb_k44_biclique_edge_check_top
  import k44bc_pkg::*;
();

  typedef struct packed {
    logic        cmd;
    logic [4:0]  idx;
    logic [31:0] bits;
    logic [4:0]  u;
    logic [4:0]  v;
  } request_t;

  typedef struct packed {
    logic creates;
    logic query;
  } answer_t;

  class biclique_tracker;
    logic [RowW-1:0] rows [MaxNodes];
    int unsigned     left_cnt;
    int unsigned     right_cnt;
    answer_t         answers_due [$];
    int              errors;

    function new();
      foreach (rows[i]) rows[i] = '0;
      left_cnt  = 32;
      right_cnt = 32;
      errors    = 0;
    endfunction

    function void set_count(logic [CfgIdxW-1:0] index, logic [CfgDataW-1:0] value);
      if (index == CfgLeftCount) begin
        left_cnt = 32'(value);
      end else begin
        right_cnt = 32'(value);
      end
    endfunction

    function logic completes_k44(logic [4:0] u, logic [4:0] v);
      logic [RowW-1:0] col_mask;
      logic [RowW-1:0] base;
      logic [RowW-1:0] cands [MaxNodes];
      int              nc;
      int              n_rows;
      n_rows   = (left_cnt > MaxNodes) ? MaxNodes : left_cnt;
      col_mask = (right_cnt >= MaxNodes) ? '1 : (RowW'(1) << right_cnt) - RowW'(1);
      base     = rows[u] & col_mask;
      base[v]  = 1'b0;
      nc       = 0;
      for (int r = 0; r < n_rows; r++) begin
        if (r != u && rows[r][v]) begin
          cands[nc] = rows[r];
          nc++;
        end
      end
      for (int i = 0; i < nc; i++) begin
        for (int j = i + 1; j < nc; j++) begin
          for (int k = j + 1; k < nc; k++) begin
            if ($countones(base & cands[i] & cands[j] & cands[k]) >= 3) return 1'b1;
          end
        end
      end
      return 1'b0;
    endfunction

    function void note_request(request_t rq);
      answer_t a;
      if (rq.cmd == CmdWriteRow) begin
        rows[rq.idx] = rq.bits;
        a.creates    = 1'b0;
        a.query      = 1'b0;
      end else begin
        a.creates = completes_k44(rq.u, rq.v);
        a.query   = 1'b1;
      end
      answers_due.insert(answers_due.size(), a);
    endfunction

    function void check_result(logic creates, logic query);
      answer_t want;
      if (answers_due.size() == 0) begin
        if (errors < 10) $display("unexpected result creates=%0b query=%0b", creates, query);
        errors++;
        return;
      end
      want = answers_due.pop_front();
      if (want.creates !== creates || want.query !== query) begin
        if (errors < 10) begin
          $display("result mismatch: expected creates=%0b query=%0b, got creates=%0b query=%0b",
                   want.creates, want.query, creates, query);
        end
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [47:0]         s_axis_tdata;
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [7:0]          m_axis_tdata;
  logic                m_axis_tuser;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  biclique_tracker tracker;
  bit              quiet;
  bit              hold_req;

  k44_biclique_edge_check_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    #(40_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : result_sink
    int stall_left;
    int hold_left;
    m_axis_tready = 1'b0;
    stall_left    = 0;
    hold_left     = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        tracker.check_result(m_axis_tdata[0], m_axis_tuser);
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 299;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic request_t make_write(int idx, logic [31:0] bits);
    request_t rq;
    rq.cmd  = CmdWriteRow;
    rq.idx  = 5'(idx);
    rq.bits = bits;
    rq.u    = 5'($urandom_range(0, 31));
    rq.v    = 5'($urandom_range(0, 31));
    return rq;
  endfunction

  function automatic request_t make_query(int u, int v);
    request_t rq;
    rq.cmd  = CmdQuery;
    rq.idx  = 5'($urandom_range(0, 31));
    rq.bits = $urandom();
    rq.u    = 5'(u);
    rq.v    = 5'(v);
    return rq;
  endfunction

  function automatic logic [31:0] row_pattern();
    case ($urandom_range(0, 3))
      0:       return $urandom();
      1:       return $urandom() & $urandom();
      2:       return $urandom() | $urandom();
      default: return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
    endcase
  endfunction

  function automatic bit is_taken(int picks [4], int n, int x);
    for (int i = 0; i < n; i++) begin
      if (picks[i] == x) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic send_request(request_t rq);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, rq.v, rq.u, rq.bits, rq.idx};
    s_axis_tuser  <= rq.cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_request(rq);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (tracker.answers_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_counts(int left, int right);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgLeftCount;
    cfg_data_i  <= CfgDataW'(left);
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.set_count(CfgLeftCount, CfgDataW'(left));
    cfg_index_i <= CfgRightCount;
    cfg_data_i  <= CfgDataW'(right);
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.set_count(CfgRightCount, CfgDataW'(right));
    cfg_valid_i <= 1'b0;
  endtask

  // Three rows share four columns and a fourth row lacks only the queried one.
  // Now and then one more column is dropped so that the planted biclique no longer completes.
  task automatic plant_and_query();
    int          r [4];
    int          c [4];
    int          row_lim;
    int          col_lim;
    logic [31:0] mask;
    row_lim = (tracker.left_cnt >= 4 && tracker.left_cnt <= 32) ? tracker.left_cnt - 1 : 31;
    col_lim = (tracker.right_cnt >= 4 && tracker.right_cnt <= 32) ? tracker.right_cnt - 1 : 31;
    for (int k = 0; k < 4; k++) begin
      do r[k] = $urandom_range(0, row_lim); while (is_taken(r, k, r[k]));
      do c[k] = $urandom_range(0, col_lim); while (is_taken(c, k, c[k]));
    end
    mask = '0;
    for (int k = 0; k < 4; k++) mask[c[k]] = 1'b1;
    for (int k = 1; k < 4; k++) begin
      send_request(make_write(r[k], mask | ($urandom() & $urandom() & $urandom())));
    end
    mask[c[0]] = 1'b0;
    if ($urandom_range(0, 3) == 0) mask[c[$urandom_range(1, 3)]] = 1'b0;
    send_request(make_write(r[0], mask | ($urandom() & $urandom() & $urandom())));
    send_request(make_query(r[0], c[0]));
  endtask

  task automatic run_phase(int n, bit pause_midway);
    int sent;
    int pick;
    bit paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < n) begin
      if (pause_midway && !paused && sent >= n / 2) begin
        drain();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        plant_and_query();
        sent += 5;
      end else if (pick < 65) begin
        send_request(make_write($urandom_range(0, 31), row_pattern()));
        sent++;
      end else begin
        send_request(make_query($urandom_range(0, 31), $urandom_range(0, 31)));
        sent++;
      end
    end
    drain();
  endtask

  initial begin
    tracker       = new();
    quiet         = 1'b0;
    hold_req      = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CfgLeftCount;
    cfg_data_i    = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_counts(32, 32);

    send_request(make_query(0, 0));
    send_request(make_query(31, 31));
    send_request(make_write(1, 32'h0000_000F));
    send_request(make_write(2, 32'h0000_000F));
    send_request(make_write(3, 32'h0000_000F));
    send_request(make_write(0, 32'h0000_000E));
    send_request(make_query(0, 0));
    send_request(make_query(0, 1));
    send_request(make_write(3, 32'h0000_0007));
    send_request(make_query(0, 0));
    send_request(make_write(31, 32'hFFFF_FFFF));
    send_request(make_write(30, 32'hFFFF_FFFF));
    send_request(make_write(29, 32'hFFFF_FFFF));
    send_request(make_query(28, 31));
    send_request(make_write(28, 32'h8000_000E));
    send_request(make_query(28, 31));
    send_request(make_query(31, 0));
    send_request(make_query(0, 31));
    send_request(make_write(0, 32'h0000_0000));
    send_request(make_query(0, 0));
    drain();

    hold_req = 1'b1;
    run_phase(15, 1'b0);
    write_counts(4, 32);
    run_phase(15, 1'b0);
    write_counts(32, 3);
    run_phase(15, 1'b0);
    write_counts(63, 40);
    run_phase(20, 1'b1);
    write_counts(0, 0);
    run_phase(10, 1'b0);
    write_counts(17, 25);
    run_phase(20, 1'b0);
    write_counts(32, 32);
    quiet = 1'b1;
    run_phase(15, 1'b0);

    repeat (20) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/k44bc_pkg.sv
hw/rtl/k44bc_dp.sv
hw/rtl/k44bc_ctrl.sv
hw/rtl/k44_biclique_edge_check_top.sv
bench/tb_k44_biclique_edge_check_top.sv
